/* rtl/ohs_pkg.sv */
// Shared constants and codes of the open-addressing hash set.
`timescale 1ns / 1ps

package ohs_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF    = 1024;
    localparam int KEY_BITS_DEF = 32;

    // Fixed port field widths
    localparam int KEY_IN_BITS = 32;
    localparam int COUNT_BITS  = 11;

    // Request kinds (kind 3 is treated as a lookup)
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_READ_ONLY = 2'd2;
    localparam logic [1:0] ST_ZERO_KEY  = 2'd3;

endpackage

/* rtl/ohs_table.sv */
// Slot store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ohs_table #(
    parameter int SLOTS    = 1024,
    parameter int KEY_BITS = 32,
    parameter int ADDR_W   = $clog2(SLOTS)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  logic [KEY_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output logic [KEY_BITS-1:0] rdata
);

    logic [KEY_BITS-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ohs_home.sv */
// Home slot unit: key modulo SLOTS, a mask for a power of two, else one bit per cycle.
`timescale 1ns / 1ps

module ohs_home #(
    parameter int SLOTS    = 1024,
    parameter int KEY_BITS = 32,
    parameter int ADDR_W   = $clog2(SLOTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] operand,
    output logic                done,
    output logic [ADDR_W-1:0]   home
);

    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_mask
            logic              done_reg;
            logic [ADDR_W-1:0] home_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    home_reg <= operand[ADDR_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
        else
        begin : g_serial
            localparam int LEFT_W = $clog2(KEY_BITS + 1);

            logic                busy_reg;
            logic                done_reg;
            logic [LEFT_W-1:0]   left_reg;
            logic [KEY_BITS-1:0] sh_reg;
            logic [ADDR_W-1:0]   rem_reg;
            logic [ADDR_W:0]     trial;
            logic [ADDR_W:0]     reduced;

            // Shift in the next key bit, subtract the modulus once if it fits
            assign trial   = {rem_reg, sh_reg[KEY_BITS-1]};
            assign reduced = (trial >= (ADDR_W + 1)'(SLOTS)) ?
                             trial - (ADDR_W + 1)'(SLOTS) : trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    left_reg <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        left_reg <= LEFT_W'(KEY_BITS);
                    end
                    else if (busy_reg)
                    begin
                        left_reg <= left_reg - 1'b1;
                        if (left_reg == LEFT_W'(1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    sh_reg  <= operand;
                    rem_reg <= '0;
                end
                else if (busy_reg)
                begin
                    sh_reg  <= sh_reg << 1;
                    rem_reg <= reduced[ADDR_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = rem_reg;
        end
    endgenerate

endmodule

/* rtl/open_addressing_hash_set.sv */
// Top level: linear-probing hash set with backward-shift deletion.
// Sequence: a zero key goes straight to the result; otherwise the home slot unit runs,
//   slots are probed downward from the home slot, and for a remove each entry of the
//   chain below the hole has its home recomputed before the result is handed out.
// Throughput: one request at a time; in_stall is high whenever the control is not idle.
// Reset: control clears at once, then a clearing pass writes all SLOTS slots to empty,
//   one per cycle, with in_stall high; configuration writes are taken.
`timescale 1ns / 1ps

module open_addressing_hash_set #(
    parameter int SLOTS    = ohs_pkg::SLOTS_DEF,
    parameter int KEY_BITS = ohs_pkg::KEY_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       kind,
    input  logic [ohs_pkg::KEY_IN_BITS-1:0]  key,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             was_present,
    output logic [1:0]                       status,
    output logic [ohs_pkg::COUNT_BITS-1:0]   count,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             read_only
);

    import ohs_pkg::*;

    localparam int ADDR_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int FULL_LIMIT = SLOTS - SLOTS / 4;

    typedef enum logic [2:0] {
        S_CLEAR,   // reset sweep of the slot store
        S_IDLE,    // wait for a request beat
        S_HOME,    // home slot unit at work
        S_PROBE,   // compare one slot per cycle, walking down
        S_SCAN,    // remove: look at the next entry below the hole
        S_SHIFT,   // remove: decide whether that entry moves back
        S_DONE     // hand the result to the output register
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_idx_reg, clr_idx_next;
    logic                read_only_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                was_present_reg, was_present_next;
    logic [1:0]          status_reg, status_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // datapath registers (no reset needed)
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [1:0]          kind_reg, kind_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]   hole_reg, hole_next;
    logic [ADDR_W-1:0]   scan_reg, scan_next;
    logic [KEY_BITS-1:0] entry_reg, entry_next;
    logic                res_present_reg, res_present_next;
    logic [1:0]          res_status_reg, res_status_next;

    // slot store and home unit hookup
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [KEY_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]   rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    logic                home_start;
    logic [KEY_BITS-1:0] home_operand;
    logic                home_done;
    logic [ADDR_W-1:0]   home;

    logic [KEY_BITS+KEY_IN_BITS-1:0] key_wide;
    logic [KEY_BITS-1:0]             key_red;
    logic [CNT_W+COUNT_BITS-1:0]     cnt_wide;
    logic                            is_ins;
    logic                            is_rem;
    logic                            found;
    logic                            move;

    // Next slot of a probe: downward, wrapping from slot 0 to the top
    function automatic logic [ADDR_W-1:0] below(input logic [ADDR_W-1:0] i);
        below = (i == '0) ? ADDR_W'(SLOTS - 1) : i - 1'b1;
    endfunction

    // Reduce the key port to KEY_BITS bits (zero-extend when wider)
    assign key_wide = {{KEY_BITS{1'b0}}, key};
    assign key_red  = key_wide[KEY_BITS-1:0];
    assign cnt_wide = {{COUNT_BITS{1'b0}}, cnt_reg};

    assign is_ins = (kind_reg == KIND_INSERT);
    assign is_rem = (kind_reg == KIND_REMOVE);
    assign found  = (rd_data == key_reg);

    // Backward shift: the entry at scan may fill the hole only if its home slot
    // does not lie cyclically between the hole and the entry itself
    assign move = ((scan_reg < hole_reg) && ((home >= hole_reg) || (home < scan_reg))) ||
                  ((scan_reg > hole_reg) && (home >= hole_reg) && (home < scan_reg));

    // One read per cycle: the home slot, the next probe slot or the next scan slot
    always_comb
    begin
        priority if (state_reg == S_HOME)
        begin
            rd_addr = home;
        end
        else if (state_reg == S_PROBE)
        begin
            rd_addr = below(idx_reg);
        end
        else
        begin
            rd_addr = below(scan_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && out_stall;
        was_present_next = was_present_reg;
        status_next      = status_reg;
        count_next       = count_reg;
        key_next         = key_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        hole_next        = hole_reg;
        scan_next        = scan_reg;
        entry_next       = entry_reg;
        res_present_next = res_present_reg;
        res_status_next  = res_status_reg;
        mem_we           = 1'b0;
        mem_waddr        = hole_reg;
        mem_wdata        = '0;
        home_start       = 1'b0;
        home_operand     = key_red;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == ADDR_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next  = key_red;
                    kind_next = kind;
                    if (key_red == '0)
                    begin
                        res_present_next = 1'b0;
                        res_status_next  = ST_ZERO_KEY;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        home_start = 1'b1;
                        state_next = S_HOME;
                    end
                end
            end

            S_HOME:
            begin
                if (home_done)
                begin
                    idx_next   = home;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                idx_next = below(idx_reg);
                if (found || (rd_data == '0))
                begin
                    res_present_next = found;
                    res_status_next  = ST_OK;
                    state_next       = S_DONE;
                    if ((is_ins || is_rem) && read_only_reg)
                    begin
                        res_status_next = ST_READ_ONLY;
                    end
                    else if (is_ins && !found)
                    begin
                        if (cnt_reg >= CNT_W'(FULL_LIMIT))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg;
                            mem_wdata = key_reg;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end
                    else if (is_rem && found)
                    begin
                        // Open a hole here and walk the chain below it
                        cnt_next   = cnt_reg - 1'b1;
                        hole_next  = idx_reg;
                        scan_next  = below(idx_reg);
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_data == '0)
                begin
                    // End of chain: empty whatever hole is left
                    mem_we     = 1'b1;
                    mem_waddr  = hole_reg;
                    mem_wdata  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    entry_next   = rd_data;
                    home_start   = 1'b1;
                    home_operand = rd_data;
                    state_next   = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                if (home_done)
                begin
                    if (move)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = hole_reg;
                        mem_wdata = entry_reg;
                        hole_next = scan_reg;
                    end
                    scan_next  = below(scan_reg);
                    state_next = S_SCAN;
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    was_present_next = res_present_reg;
                    status_next      = res_status_reg;
                    count_next       = cnt_wide[COUNT_BITS-1:0];
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            read_only_reg   <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            was_present_reg <= 1'b0;
            status_reg      <= ST_OK;
            count_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            was_present_reg <= was_present_next;
            status_reg      <= status_next;
            count_reg       <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                read_only_reg <= read_only;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        hole_reg        <= hole_next;
        scan_reg        <= scan_next;
        entry_reg       <= entry_next;
        res_present_reg <= res_present_next;
        res_status_reg  <= res_status_next;
    end

    ohs_table #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS),
        .ADDR_W   (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ohs_home #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS),
        .ADDR_W   (ADDR_W)
    ) u_home (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (home_start),
        .operand (home_operand),
        .done    (home_done),
        .home    (home)
    );

    // Take a request beat only when idle; config is always taken
    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign was_present = was_present_reg;
    assign status      = status_reg;
    assign count       = count_reg;

endmodule

/* rtl/ohs_checker.sv */
// Port-level checks of the hash set, bound to the top level.
`timescale 1ns / 1ps

module ohs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       was_present,
    input logic [1:0] status
);

    import ohs_pkg::*;

    // A result beat that is stalled stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A request beat keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken without going busy");

    // A zero key is never reported as present
    a_zero_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ZERO_KEY) |-> !was_present)
        else $error("zero key reported present");

    // Full is only answered for an absent key
    a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> !was_present)
        else $error("full status for a present key");

endmodule

bind open_addressing_hash_set ohs_checker u_ohs_checker (.*);

/* tb/sv/open_addressing_hash_set_tb.sv */
// Self-checking testbench of the open-addressing hash set: directed and random requests.
`timescale 1ns / 1ps

module open_addressing_hash_set_tb;

    import ohs_pkg::*;

    localparam int SLOT_COUNT    = SLOTS_DEF;
    localparam int FULL_MARK     = SLOT_COUNT - SLOT_COUNT / 4;
    // Worst wait with no beat: clearing pass, longest remove, long receiver hold-off.
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 16;
    localparam int POOL_SIZE     = 48;

    typedef struct packed {
        logic                  was_present;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] count;
    } set_result_t;

    // DUT connections; every input is known from time zero
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [1:0]             kind        = KIND_LOOKUP;
    logic [KEY_IN_BITS-1:0] key         = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic                   was_present;
    logic [1:0]             status;
    logic [COUNT_BITS-1:0]  count;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic                   read_only   = 1'b0;

    // Mirror of the set: slot contents, element count and the read-only register
    logic [KEY_IN_BITS-1:0] slot_mirror [SLOT_COUNT];
    int unsigned            held_keys;
    logic                   ro_mode;

    set_result_t            awaited_results [$];
    int unsigned            mismatches     = 0;
    int unsigned            results_seen   = 0;
    int unsigned            quiet_cycles   = 0;

    // Idling knobs (percent of cycles) and the receiver hold-off counter
    int unsigned            send_idle_pct  = 0;
    int unsigned            recv_idle_pct  = 0;
    int unsigned            hold_left      = 0;

    logic [KEY_IN_BITS-1:0] key_pool [POOL_SIZE];
    logic [KEY_IN_BITS-1:0] fill_keys [FULL_MARK];

    open_addressing_hash_set i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .was_present (was_present),
        .status      (status),
        .count       (count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .read_only   (read_only)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Set mirror
    // ------------------------------------------------------------------

    function automatic int unsigned home_slot(input logic [KEY_IN_BITS-1:0] k);
        return k % SLOT_COUNT;
    endfunction

    // Probe direction is downward, wrapping from slot 0 to the top slot
    function automatic int unsigned slot_below(input int unsigned i);
        return (i == 0) ? SLOT_COUNT - 1 : i - 1;
    endfunction

    // Empty the hole and pull back every later chain entry whose home allows it
    function automatic void close_gap(input int unsigned hole);
        int unsigned scan;
        int unsigned want;
        scan = hole;
        for (int n = 0; n < SLOT_COUNT; n++)
        begin
            scan = slot_below(scan);
            if (slot_mirror[scan] == '0)
                break;
            want = home_slot(slot_mirror[scan]);
            if ((scan < hole && (want >= hole || want < scan)) ||
                (scan > hole && want >= hole && want < scan))
            begin
                slot_mirror[hole] = slot_mirror[scan];
                hole = scan;
            end
        end
        slot_mirror[hole] = '0;
    endfunction

    function automatic set_result_t apply_request(input logic [1:0] op,
                                                  input logic [KEY_IN_BITS-1:0] k);
        set_result_t r;
        int unsigned pos;
        logic        hit;
        r.was_present = 1'b0;
        r.status      = ST_OK;
        hit           = 1'b0;
        if (k == '0)
        begin
            r.status = ST_ZERO_KEY;
        end
        else
        begin
            pos = home_slot(k);
            for (int n = 0; n < SLOT_COUNT; n++)
            begin
                if (slot_mirror[pos] == '0)
                    break;
                if (slot_mirror[pos] == k)
                begin
                    hit = 1'b1;
                    break;
                end
                pos = slot_below(pos);
            end
            r.was_present = hit;
            // the unused kind falls through as a lookup
            if (op == KIND_INSERT || op == KIND_REMOVE)
            begin
                if (ro_mode)
                begin
                    r.status = ST_READ_ONLY;
                end
                else if (op == KIND_INSERT)
                begin
                    if (!hit)
                    begin
                        if (held_keys >= FULL_MARK)
                        begin
                            r.status = ST_FULL;
                        end
                        else
                        begin
                            slot_mirror[pos] = k;
                            held_keys++;
                        end
                    end
                end
                else if (hit)
                begin
                    held_keys--;
                    close_gap(pos);
                end
            end
        end
        r.count = held_keys[COUNT_BITS-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off when one is requested
    // ------------------------------------------------------------------

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        set_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %0d: present=%0b status=%0d count=%0d",
                             results_seen, was_present, status, count);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (want.was_present !== was_present || want.status !== status ||
                    want.count !== count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected present=%0b status=%0d count=%0d, got present=%0b status=%0d count=%0d",
                                 results_seen, want.was_present, want.status, want.count,
                                 was_present, status, count);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Offer one request; valid stays high after the beat so that the next
    // request can follow without a bubble.
    task automatic send_request(input logic [1:0] op, input logic [KEY_IN_BITS-1:0] k);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited_results.push_back(apply_request(op, k));
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_read_only(input logic value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        read_only <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ro_mode = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_IN_BITS-1:0] clustered_key();
        logic [9:0]  home;
        logic [21:0] upper;
        // Crowd keys around the wrap point and one mid region so chains form
        case ($urandom_range(2))
            0:       home = 10'(1020 + $urandom_range(7));
            1:       home = 10'(300 + $urandom_range(15));
            default: home = 10'($urandom);
        endcase
        upper = 22'($urandom);
        if (upper == '0 && home == '0)
            home = 10'd1;
        return {upper, home};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero key, extremes of the key, every kind, duplicates and absent removes
    task automatic test_basic_ops();
        write_read_only(1'b0);
        send_request(KIND_LOOKUP, '0);
        send_request(KIND_INSERT, '0);
        send_request(KIND_REMOVE, '0);
        send_request(2'd3, '0);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF);
        send_request(2'd3, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_REMOVE, 32'h0000_0001);
        send_request(KIND_REMOVE, 32'hFFFF_FFFF);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF);
    endtask

    // Collide keys on home slot 1 so the chain wraps past slot 0, then remove
    // from the chain head and middle so entries are shifted back.
    task automatic test_wrap_and_shift();
        send_request(KIND_INSERT, 32'h0000_0001);
        send_request(KIND_INSERT, 32'h0000_0401);
        send_request(KIND_INSERT, 32'h0000_0801);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'h0000_03FF);
        send_request(KIND_REMOVE, 32'h0000_0001);
        send_request(KIND_LOOKUP, 32'h0000_0801);
        send_request(KIND_LOOKUP, 32'h8000_0000);
        send_request(KIND_REMOVE, 32'h0000_0401);
        send_request(KIND_LOOKUP, 32'h0000_03FF);
        send_request(KIND_REMOVE, 32'h0000_0801);
        send_request(KIND_REMOVE, 32'h8000_0000);
        send_request(KIND_REMOVE, 32'h0000_03FF);
    endtask

    // With writes locked, inserts and removes report the true presence only
    task automatic test_read_only();
        send_request(KIND_INSERT, 32'h1234_5678);
        write_read_only(1'b1);
        send_request(KIND_INSERT, 32'h1234_5678);
        send_request(KIND_INSERT, 32'h0BAD_F00D);
        send_request(KIND_REMOVE, 32'h1234_5678);
        send_request(KIND_REMOVE, 32'h0BAD_F00D);
        send_request(KIND_LOOKUP, 32'h1234_5678);
        send_request(KIND_INSERT, '0);
        write_read_only(1'b0);
        send_request(KIND_REMOVE, 32'h1234_5678);
    endtask

    // Fill to the three-quarter mark on distinct homes, hit the full status,
    // then empty the table from the lowest home upward to keep scans short.
    task automatic test_table_full();
        for (int i = 0; i < FULL_MARK; i++)
        begin
            fill_keys[i] = {22'($urandom_range(1, 32'h3F_FFFF)), 10'(i)};
            send_request(KIND_INSERT, fill_keys[i]);
        end
        send_request(KIND_INSERT, 32'h5555_53FF);
        send_request(KIND_INSERT, fill_keys[FULL_MARK / 2]);
        send_request(KIND_LOOKUP, 32'h5555_53FF);
        write_read_only(1'b1);
        send_request(KIND_INSERT, 32'h5555_53FF);
        write_read_only(1'b0);
        for (int i = 0; i < FULL_MARK; i++)
            send_request(KIND_REMOVE, fill_keys[i]);
    endtask

    // Hold the receiver off while the sender keeps offering, then pause the
    // sender until the block has answered everything.
    task automatic test_backpressure();
        send_idle_pct = 0;
        @(negedge clk);
        hold_left = 300;
        for (int i = 0; i < 12; i++)
            send_request((i % 3 == 2) ? KIND_REMOVE : KIND_INSERT, clustered_key());
        wait_results_drained();
        for (int i = 0; i < 6; i++)
            send_request(KIND_LOOKUP, clustered_key());
        wait_results_drained();
    endtask

    // Mostly requests on a reused key pool so hits, shifts and wraps are
    // frequent; some fresh random and zero keys as noise.
    task automatic test_random_traffic();
        logic [1:0]             op;
        logic [KEY_IN_BITS-1:0] k;
        int unsigned            pick;
        int unsigned            roll;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = clustered_key();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 265; n++)
            begin
                // lock writes for a short burst mid phase
                if (n == 130)
                    write_read_only(1'b1);
                if (n == 145)
                    write_read_only(1'b0);
                roll = $urandom_range(99);
                if (roll < 40)
                    op = KIND_INSERT;
                else if (roll < 70)
                    op = KIND_REMOVE;
                else if (roll < 95)
                    op = KIND_LOOKUP;
                else
                    op = 2'd3;
                pick = $urandom_range(POOL_SIZE - 1);
                roll = $urandom_range(99);
                if (roll < 5)
                begin
                    k = '0;
                end
                else if (roll < 15)
                begin
                    k = $urandom;
                end
                else if (roll < 25)
                begin
                    key_pool[pick] = clustered_key();
                    k = key_pool[pick];
                end
                else
                begin
                    k = key_pool[pick];
                end
                send_request(op, k);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
            slot_mirror[i] = '0;
        held_keys     = 0;
        ro_mode       = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 78;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_wrap_and_shift();
        test_read_only();
        test_table_full();
        test_backpressure();
        test_random_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/ohs_pkg.sv
rtl/ohs_table.sv
rtl/ohs_home.sv
rtl/open_addressing_hash_set.sv
rtl/ohs_checker.sv
tb/sv/open_addressing_hash_set_tb.sv
